[src/cpbps_pkg.sv]
// Shared constants and types for the closest pair between point sets unit.
package cpbps_pkg;

    localparam int MAX_REFS    = 1024;
    localparam int MAX_QUERIES = 65536;
    localparam int DIMENSIONS  = 3;

    localparam int COORD_W   = 16;
    localparam int REF_AW    = $clog2(MAX_REFS);
    localparam int REF_CW    = $clog2(MAX_REFS + 1);
    localparam int QUERY_W   = 16;
    localparam int REF_IDX_W = 10;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = 34;
    localparam int BEST_W    = DIST_W + 1;
    localparam int ROOT_W    = DIST_W / 2;
    localparam int POINT_W   = DIMENSIONS * COORD_W;

    localparam logic [QUERY_W-1:0] QUERY_LIMIT =
        (MAX_QUERIES - 1 < 65535) ? QUERY_W'(MAX_QUERIES - 1) : {QUERY_W{1'b1}};
    localparam logic [BEST_W-1:0] BEST_NONE = {BEST_W{1'b1}};
    localparam logic [REF_CW-1:0] REF_FULL  = REF_CW'(MAX_REFS);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ROOT,
        ST_EMIT
    } t_state;

endpackage

[src/cpbps_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module cpbps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/cpbps_isqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
module cpbps_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cpbps_pkg::DIST_W-1:0] i_value,
    output logic                        o_done,
    output logic [cpbps_pkg::ROOT_W-1:0] o_root
);
    import cpbps_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIST_W-1:0] r_val;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic              take;

    // Bring down the next two bits and try to subtract 4*root + 1.
    assign rem_sh = {r_rem, r_val[DIST_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[DIST_W-3:0], 2'b00};
            r_rem  <= take ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[src/closest_pair_between_point_sets_unit.sv]
// Top level of the closest pair between point sets unit.
//
// Usage: the input channel (i_valid / o_ready) carries one transaction per point.
// Transactions with i_cmd = 0 load reference points into an on-chip 1024-entry
// memory, one per cycle; i_last closes the reference set, and a load after the set
// was closed starts a new set. Transactions with i_cmd = 1 are queries: each query
// reads every stored reference once, one memory read per cycle, through a
// five-stage pipeline (read, difference, square, sum, compare). A query therefore
// occupies the unit until every stored reference has passed the pipeline, since
// the reference memory has a single read port. The query flagged by i_last then
// runs a bit-serial square root and places one result transaction in the output
// register (o_valid / i_ready), after which the running minimum and query counter
// clear.
// Reference loads are taken back to back. While the output register is full and
// the receiver stalls, the unit still loads references and runs non-final
// queries; a second final query waits in its emit step until the register frees.
// Synchronous active-low reset empties the reference set, clears the query
// counter and the running minimum, and drops o_valid. No clearing pass is needed,
// since only entries below the fill count are ever read.
module closest_pair_between_point_sets_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_cmd,
    input  logic signed [cpbps_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [cpbps_pkg::COORD_W-1:0] i_y_coord,
    input  logic signed [cpbps_pkg::COORD_W-1:0] i_z_coord,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cpbps_pkg::DIST_W-1:0]    o_dist_squared,
    output logic [cpbps_pkg::ROOT_W-1:0]    o_dist_root,
    output logic [cpbps_pkg::QUERY_W-1:0]   o_query_index,
    output logic [cpbps_pkg::REF_IDX_W-1:0] o_ref_index,
    output logic                            o_found
);
    import cpbps_pkg::*;

    // Absolute difference of two signed coordinates; it always fits the coordinate width.
    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    endfunction

    t_state r_state, n_state;

    // Handshake and control decode.
    logic in_accept;
    logic load_accept;
    logic query_accept;
    logic rd_en;
    logic sqrt_start;
    logic sqrt_done;
    logic out_load;
    logic pipe_empty;
    logic last_addr;

    // Reference set bookkeeping.
    logic [REF_CW-1:0]  r_ref_count;
    logic               r_refs_closed;
    logic [QUERY_W-1:0] r_query_count;
    logic [REF_CW-1:0]  base_count;
    logic               ram_we;

    // Current query.
    logic [COORD_W-1:0] r_qx, r_qy, r_qz;
    logic [QUERY_W-1:0] r_qidx;
    logic               r_qlast;
    logic [REF_AW-1:0]  r_addr;

    // Scan pipeline.
    logic [POINT_W-1:0] rd_data;
    logic               r_v1, r_v2, r_v3, r_v4;
    logic [REF_AW-1:0]  r_i1, r_i2, r_i3, r_i4;
    logic [COORD_W-1:0] r_ad [0:DIMENSIONS-1];
    logic [SQ_W-1:0]    r_sq [0:DIMENSIONS-1];
    logic [DIST_W-1:0]  r_sum;

    // Running minimum.
    logic [BEST_W-1:0]  r_best_dist;
    logic [QUERY_W-1:0] r_best_query;
    logic [REF_AW-1:0]  r_best_ref;
    logic               best_found;

    logic [ROOT_W-1:0]  sqrt_root;

    // Output register.
    logic                 r_out_valid;
    logic [DIST_W-1:0]    r_out_dist;
    logic [ROOT_W-1:0]    r_out_root;
    logic [QUERY_W-1:0]   r_out_query;
    logic [REF_IDX_W-1:0] r_out_ref;
    logic                 r_out_found;

    assign in_accept    = i_valid && o_ready;
    assign load_accept  = in_accept && (i_cmd == CMD_LOAD);
    assign query_accept = in_accept && (i_cmd == CMD_QUERY);
    assign pipe_empty   = !(r_v1 || r_v2 || r_v3 || r_v4);
    assign last_addr    = (REF_CW'(r_addr) + 1'b1 == r_ref_count);
    assign best_found   = (r_best_dist != BEST_NONE);

    // A load into a closed set restarts the set at entry zero.
    assign base_count = r_refs_closed ? '0 : r_ref_count;
    assign ram_we     = load_accept && (base_count < REF_FULL);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (query_accept) begin
                    n_state = (r_ref_count == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = r_qlast ? ST_ROOT : ST_IDLE;
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State-dependent control outputs.
    always_comb begin
        o_ready    = 1'b0;
        rd_en      = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE:  o_ready    = 1'b1;
            ST_SCAN:  rd_en      = 1'b1;
            ST_DRAIN: sqrt_start = pipe_empty && r_qlast;
            ST_EMIT:  out_load   = !r_out_valid || i_ready;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    cpbps_ram #(
        .WIDTH(POINT_W),
        .DEPTH(MAX_REFS)
    ) u_ref_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_wr_addr(base_count[REF_AW-1:0]),
        .i_wr_data({i_z_coord, i_y_coord, i_x_coord}),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_addr),
        .o_rd_data(rd_data)
    );

    cpbps_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sqrt_start),
        .i_value(r_best_dist[DIST_W-1:0]),
        .o_done (sqrt_done),
        .o_root (sqrt_root)
    );

    // Control state, set bookkeeping and the running minimum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ref_count   <= '0;
            r_refs_closed <= 1'b0;
            r_query_count <= '0;
            r_best_dist   <= BEST_NONE;
            r_best_query  <= '0;
            r_best_ref    <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_v4          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= rd_en;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;

            if (load_accept) begin
                r_refs_closed <= i_last;
                r_ref_count   <= ram_we ? base_count + 1'b1 : base_count;
                if (r_refs_closed) begin
                    r_query_count <= '0;
                    r_best_dist   <= BEST_NONE;
                    r_best_query  <= '0;
                    r_best_ref    <= '0;
                end
            end

            if (query_accept) begin
                r_refs_closed <= 1'b1;
                if (r_query_count < QUERY_LIMIT) begin
                    r_query_count <= r_query_count + 1'b1;
                end
            end

            // Strict less-than: the earliest query and the lowest reference keep ties.
            if (r_v4 && ({1'b0, r_sum} < r_best_dist)) begin
                r_best_dist  <= {1'b0, r_sum};
                r_best_query <= r_qidx;
                r_best_ref   <= r_i4;
            end

            // The batch minimum clears as soon as its result is captured.
            if (out_load) begin
                r_query_count <= '0;
                r_best_dist   <= BEST_NONE;
                r_best_query  <= '0;
                r_best_ref    <= '0;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query capture and scan address.
    always_ff @(posedge i_clk) begin
        if (query_accept) begin
            r_qx    <= i_x_coord;
            r_qy    <= i_y_coord;
            r_qz    <= i_z_coord;
            r_qidx  <= r_query_count;
            r_qlast <= i_last;
            r_addr  <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    // Distance pipeline: difference, square, sum.
    always_ff @(posedge i_clk) begin
        r_i1 <= r_addr;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;

        r_ad[0] <= abs_diff(r_qx, rd_data[COORD_W-1:0]);
        r_ad[1] <= abs_diff(r_qy, rd_data[2*COORD_W-1:COORD_W]);
        r_ad[2] <= abs_diff(r_qz, rd_data[3*COORD_W-1:2*COORD_W]);

        for (int k = 0; k < DIMENSIONS; k++) begin
            r_sq[k] <= r_ad[k] * r_ad[k];
        end

        r_sum <= DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2]);
    end

    // Result capture; a batch without references reports all zeros.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found <= best_found;
            r_out_dist  <= best_found ? r_best_dist[DIST_W-1:0] : '0;
            r_out_root  <= best_found ? sqrt_root : '0;
            r_out_query <= best_found ? r_best_query : '0;
            r_out_ref   <= best_found ? REF_IDX_W'(r_best_ref) : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_dist_squared = r_out_dist;
    assign o_dist_root    = r_out_root;
    assign o_query_index  = r_out_query;
    assign o_ref_index    = r_out_ref;
    assign o_found        = r_out_found;

endmodule

[src/cpbps_checker.sv]
// Port-level assertions for the closest pair unit, bound to the top level.
module cpbps_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            i_cmd,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [cpbps_pkg::DIST_W-1:0]    o_dist_squared,
    input logic [cpbps_pkg::ROOT_W-1:0]    o_dist_root,
    input logic [cpbps_pkg::QUERY_W-1:0]   o_query_index,
    input logic [cpbps_pkg::REF_IDX_W-1:0] o_ref_index,
    input logic                            o_found
);
    import cpbps_pkg::*;

    logic [DIST_W+1:0] root_sq;
    logic [DIST_W+1:0] next_sq;

    assign root_sq = (DIST_W+2)'(o_dist_root) * (DIST_W+2)'(o_dist_root);
    assign next_sq = ((DIST_W+2)'(o_dist_root) + 1'b1) * ((DIST_W+2)'(o_dist_root) + 1'b1);

    // A pending result holds until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dist_squared) && $stable(o_query_index))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // A batch without references reports all fields as zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_dist_squared == '0 && o_dist_root == '0 &&
                                o_query_index == '0 && o_ref_index == '0)
        else $error("not-found result carries nonzero fields");

    // The reported root is the floor square root of the reported distance.
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> root_sq <= (DIST_W+2)'(o_dist_squared) &&
                               next_sq > (DIST_W+2)'(o_dist_squared))
        else $error("root is not the floor square root of the distance");

    // A query keeps the unit busy for at least the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_cmd == CMD_QUERY |=> !o_ready)
        else $error("unit ready right after accepting a query");

endmodule

bind closest_pair_between_point_sets_unit cpbps_checker u_cpbps_checker (.*);

[tb/sv/closest_pair_between_point_sets_unit_tb.sv]
// Self-checking testbench for the closest pair between point sets unit.
`timescale 1ns / 1ps

module closest_pair_between_point_sets_unit_tb;

    import cpbps_pkg::*;

    // One point transaction as the driver presents it. The hold bit makes the
    // driver wait until every pending closest pair has come out, and the
    // no_gap bit suppresses idle cycles after the transaction.
    typedef struct packed {
        logic                 cmd;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   z;
        logic                 last;
        logic                 hold;
        logic                 no_gap;
    } t_point;

    // One closest pair result as the unit should report it.
    typedef struct packed {
        logic [DIST_W-1:0]    dsq;
        logic [ROOT_W-1:0]    root;
        logic [QUERY_W-1:0]   qidx;
        logic [REF_IDX_W-1:0] ridx;
        logic                 found;
    } t_closest;

    // Block ports.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_cmd = CMD_LOAD;
    logic [COORD_W-1:0]   i_x_coord = '0;
    logic [COORD_W-1:0]   i_y_coord = '0;
    logic [COORD_W-1:0]   i_z_coord = '0;
    logic                 i_last = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [DIST_W-1:0]    o_dist_squared;
    logic [ROOT_W-1:0]    o_dist_root;
    logic [QUERY_W-1:0]   o_query_index;
    logic [REF_IDX_W-1:0] o_ref_index;
    logic                 o_found;

    closest_pair_between_point_sets_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_z_coord      (i_z_coord),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_dist_squared (o_dist_squared),
        .o_dist_root    (o_dist_root),
        .o_query_index  (o_query_index),
        .o_ref_index    (o_ref_index),
        .o_found        (o_found)
    );

    // Points waiting to be driven, and closest pairs waiting to come out.
    t_point   point_q[$];
    t_closest closest_q[$];

    // Shadow copy of the unit's state, updated once per accepted transaction.
    logic [COORD_W-1:0]   ref_x [MAX_REFS];
    logic [COORD_W-1:0]   ref_y [MAX_REFS];
    logic [COORD_W-1:0]   ref_z [MAX_REFS];
    int unsigned          n_refs = 0;
    bit                   set_closed = 1'b0;
    logic [QUERY_W-1:0]   q_count = '0;
    logic [BEST_W-1:0]    best_d = BEST_NONE;
    logic [QUERY_W-1:0]   best_q = '0;
    logic [REF_IDX_W-1:0] best_r = '0;

    // Stimulus bookkeeping.
    bit          hold_next = 1'b0;
    bit          burst = 1'b0;
    int unsigned items_queued = 0;
    int unsigned points_total = 0;
    int unsigned points_sent = 0;
    int unsigned pairs_seen = 0;
    int unsigned mismatches = 0;

    // Handshake pacing state.
    bit          taken = 1'b0;
    bit          busy = 1'b0;
    bit          quiet = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    t_point      cur;

    // Floor square root, found one result bit at a time from the top.
    function automatic logic [ROOT_W-1:0] floor_root(input logic [DIST_W-1:0] n);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] t;
        longint unsigned   tt;
        int                b;
        r = '0;
        for (b = ROOT_W - 1; b >= 0; b--) begin
            t  = r | (ROOT_W'(1) << b);
            tt = 64'(t);
            if (tt * tt <= n) r = t;
        end
        return r;
    endfunction

    function automatic void clear_batch();
        q_count = '0;
        best_d  = BEST_NONE;
        best_q  = '0;
        best_r  = '0;
    endfunction

    // Applies one accepted point to the shadow state. A query scans every stored
    // reference; the final query of a batch queues the closest pair it reports.
    function automatic void track_closest_pair(input t_point p);
        longint          dx, dy, dz;
        longint unsigned d;
        int unsigned     i;
        t_closest        r;
        if (p.cmd == CMD_LOAD) begin
            // A load after the set was closed starts a fresh set.
            if (set_closed) begin
                n_refs     = 0;
                set_closed = 1'b0;
                clear_batch();
            end
            // Loads beyond the memory size are dropped, but their last flag counts.
            if (n_refs < MAX_REFS) begin
                ref_x[n_refs] = p.x;
                ref_y[n_refs] = p.y;
                ref_z[n_refs] = p.z;
                n_refs++;
            end
            if (p.last) set_closed = 1'b1;
        end else begin
            set_closed = 1'b1;
            for (i = 0; i < n_refs; i++) begin
                dx = longint'($signed(ref_x[i])) - longint'($signed(p.x));
                dy = longint'($signed(ref_y[i])) - longint'($signed(p.y));
                dz = longint'($signed(ref_z[i])) - longint'($signed(p.z));
                d = dx * dx + dy * dy + dz * dz;
                // Strict less-than: the earliest query and lowest reference win ties.
                if (d < best_d) begin
                    best_d = d[BEST_W-1:0];
                    best_q = q_count;
                    best_r = i[REF_IDX_W-1:0];
                end
            end
            if (q_count < QUERY_LIMIT) q_count++;
            if (p.last) begin
                if (best_d == BEST_NONE) begin
                    r = '0;
                end else begin
                    r.dsq   = best_d[DIST_W-1:0];
                    r.root  = floor_root(best_d[DIST_W-1:0]);
                    r.qidx  = best_q;
                    r.ridx  = best_r;
                    r.found = 1'b1;
                end
                closest_q = {closest_q, r};
                clear_batch();
            end
        end
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pair %0d: %s expected %0d, got %0d", pairs_seen, name, want, got);
        end
    endfunction

    function automatic void add_point(input logic cmd, input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [COORD_W-1:0] z, input logic last);
        t_point p;
        p.cmd    = cmd;
        p.x      = x;
        p.y      = y;
        p.z      = z;
        p.last   = last;
        p.hold   = hold_next;
        p.no_gap = burst;
        hold_next = 1'b0;
        point_q = {point_q, p};
        items_queued++;
    endfunction

    // Coordinates: mostly a tight cluster near the origin so that distances tie
    // often, plus full-range values and both extremes.
    function automatic logic [COORD_W-1:0] pick_coord();
        int unsigned r;
        int          t;
        r = $urandom_range(0, 99);
        if (r < 5) return 16'h8000;
        if (r < 10) return 16'h7fff;
        if (r < 35) begin
            t = $urandom;
            return t[COORD_W-1:0];
        end
        t = $urandom_range(0, 40);
        t -= 20;
        return t[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c);
        int t;
        t = $urandom_range(0, 4);
        t -= 2;
        return c + t[COORD_W-1:0];
    endfunction

    // Idle length for both channels: mostly none or short, sometimes long,
    // and nothing at all during quiet stretches.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Quiet stretches come and go, redrawn at random from the cycle counter.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count % 1500 == 0) quiet = ($urandom_range(0, 3) == 0);
    end

    // Driver: presents the next queued point at the falling edge once the slot is
    // free and the idle gap has run out. Valid stays high until the transaction is
    // accepted, and a point flagged hold waits until no closest pair is pending.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (taken) begin
                taken    = 1'b0;
                busy     = 1'b0;
                gap_left = cur.no_gap ? 0 : idle_len();
            end
            if (!busy) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (point_q.size() != 0 &&
                             !(point_q[0].hold && closest_q.size() != 0)) begin
                    cur       = point_q.pop_front();
                    busy      = 1'b1;
                    i_valid   <= 1'b1;
                    i_cmd     <= cur.cmd;
                    i_x_coord <= cur.x;
                    i_y_coord <= cur.y;
                    i_z_coord <= cur.z;
                    i_last    <= cur.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready is high except during random stalls.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    // Monitor: on each accepted input transaction the shadow state advances, and
    // each accepted result is compared with the oldest pending closest pair.
    always @(posedge i_clk) begin
        t_closest want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                track_closest_pair(cur);
                points_sent++;
                taken = 1'b1;
            end
            if (o_valid && i_ready) begin
                if (closest_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pair %0d: result with nothing pending, dist_squared %0d",
                                 pairs_seen, o_dist_squared);
                end else begin
                    want = closest_q.pop_front();
                    check_field("dist_squared", 64'(want.dsq), 64'(o_dist_squared));
                    check_field("dist_root", 64'(want.root), 64'(o_dist_root));
                    check_field("query_index", 64'(want.qidx), 64'(o_query_index));
                    check_field("ref_index", 64'(want.ridx), 64'(o_ref_index));
                    check_field("found", 64'(want.found), 64'(o_found));
                end
                pairs_seen++;
            end
        end
    end

    // Main sequence: build all stimulus, release reset, then wait for the drain.
    initial begin
        int unsigned i, j, kind, nref, nq, batches;
        logic [COORD_W-1:0] px, py, pz;

        // Directed: a final query with no references loaded reports nothing found.
        add_point(CMD_QUERY, '0, '0, '0, 1'b1);
        // Extreme corners give the largest squared distance and root.
        add_point(CMD_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        add_point(CMD_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
        // Equal distances within one query: the lowest reference index wins.
        add_point(CMD_LOAD, 16'sd10, '0, '0, 1'b0);
        add_point(CMD_LOAD, -16'sd10, '0, '0, 1'b0);
        add_point(CMD_LOAD, '0, 16'sd10, '0, 1'b1);
        add_point(CMD_QUERY, '0, '0, '0, 1'b1);
        // Queries reuse the closed set; the sender first waits for the result
        // above. Equal distances across queries keep the earlier query.
        hold_next = 1'b1;
        add_point(CMD_QUERY, '0, '0, 16'sd1, 1'b0);
        add_point(CMD_QUERY, '0, '0, '0, 1'b0);
        add_point(CMD_QUERY, '0, '0, '0, 1'b1);
        // A query closes an open set and scans only what was stored so far.
        add_point(CMD_LOAD, 16'sd1, 16'sd2, 16'sd3, 1'b0);
        add_point(CMD_LOAD, -16'sd4, 16'sd5, -16'sd6, 1'b0);
        add_point(CMD_QUERY, 16'sd1, 16'sd2, 16'sd3, 1'b1);
        // A load after that query starts a new set.
        add_point(CMD_LOAD, 16'sd7, 16'sd7, 16'sd7, 1'b1);
        add_point(CMD_QUERY, 16'sd8, 16'sd8, 16'sd8, 1'b1);
        // A load after a closing load also starts a new set.
        add_point(CMD_LOAD, 16'sd100, 16'sd100, 16'sd100, 1'b1);
        add_point(CMD_LOAD, 16'sd200, -16'sd200, 16'sd200, 1'b1);
        add_point(CMD_QUERY, 16'sd101, 16'sd100, 16'sd100, 1'b1);

        // Back-to-back queries against one reference; the closest comes last.
        add_point(CMD_LOAD, '0, '0, '0, 1'b1);
        burst = 1'b1;
        for (i = 0; i < 6; i++) add_point(CMD_QUERY, 16'sd1000, 16'sd1000, 16'sd1000, 1'b0);
        for (i = 5; i >= 1; i--) add_point(CMD_QUERY, COORD_W'(i), '0, '0, i == 1);
        burst = 1'b0;

        // Random batches, mostly well formed, until enough points.
        batches = 0;
        px = '0;
        py = '0;
        pz = '0;
        while (items_queued < 580) begin
            batches++;
            kind = $urandom_range(0, 99);
            if (batches % 20 == 0) hold_next = 1'b1;
            if (kind < 90) begin
                nref = 0;
                if (kind < 65)
                    nref = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                       : $urandom_range(1, 12);
                else if (kind >= 78)
                    nref = $urandom_range(1, 8);
                for (i = 0; i < nref; i++) begin
                    px = pick_coord();
                    py = pick_coord();
                    pz = pick_coord();
                    // Broken batches scatter the last flag or leave the set open.
                    add_point(CMD_LOAD, px, py, pz,
                              (kind < 65) ? (i == nref - 1) : ($urandom_range(0, 3) == 0));
                end
                nq = (kind < 65) ? $urandom_range(1, 6) : $urandom_range(1, 4);
                for (j = 0; j < nq; j++) begin
                    if ($urandom_range(0, 3) == 0)
                        add_point(CMD_QUERY, near(px), near(py), near(pz), j == nq - 1);
                    else
                        add_point(CMD_QUERY, pick_coord(), pick_coord(), pick_coord(),
                                  (kind >= 78 && $urandom_range(0, 1) == 0) ?
                                  ($urandom_range(0, 2) == 0) : (j == nq - 1));
                end
            end else begin
                // Noise: random commands and flags.
                nq = $urandom_range(1, 6);
                for (j = 0; j < nq; j++)
                    add_point(($urandom_range(0, 1) == 0) ? CMD_LOAD : CMD_QUERY,
                              pick_coord(), pick_coord(), pick_coord(),
                              $urandom_range(0, 3) == 0);
            end
        end
        points_total = point_q.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (points_sent != points_total) @(posedge i_clk);
        while (closest_q.size() != 0) @(posedge i_clk);
        // A trailing non-final query may still be scanning.
        repeat (1100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #10000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
